>>> sv/rcch_pkg.sv
// ----------------------------------------------------------------------------
// rcch_pkg: shared definitions for the ray/circle closest-hit unit
// Register indexes of the configuration port and fixed field widths.
// ----------------------------------------------------------------------------
package rcch_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXCL_ID   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXCL_EN   = 3'd6;

    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 160;
    localparam int MUL_W      = 35;

    typedef logic [63:0] sq_dist_t;

endpackage

>>> sv/ray_circle_closest_hit_unit.sv
// ----------------------------------------------------------------------------
// ray_circle_closest_hit_unit: closest hit of a 2D ray against a circle stream
// Normalizes the ray, intersects each circle through one shared multiplier
// and one shared subtractor, and keeps the nearest valid hit per query.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tdata: id, cx, cy, radius; tlast
//  m_*      | out | m_tvalid/m_tready  | tdata: id, x, y, sq dist; tuser: hit
//  cfg_*    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  A circle that is not cut short runs two 32-step square roots and two
//  (FRAC_BITS+1)-step divides on the shared subtractor, plus fifteen issues
//  of the shared multiplier; the default FRAC_BITS gives Q16.16.
//  An excluded circle skips to the end state. s_tready is high only when idle.
//  A result waits in the output register; a query end stalls only if the
//  previous result is still untaken. Reset is synchronous, active low.
module ray_circle_closest_hit_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entity_id[31:0], center_x[63:32], center_y[95:64], radius[126:96]
    input  logic [rcch_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hit_entity[31:0], hit_x[63:32], hit_y[95:64], hit_sq_distance[159:96]
    output logic [rcch_pkg::OUT_DATA_W-1:0]   m_tdata,
    // hit[0]
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rcch_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data
);

    localparam int UW    = FRAC_BITS + 2;
    localparam int QW    = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(FRAC_BITS);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_MDX  = 5'd1;
    localparam logic [4:0] ST_MDY  = 5'd2;
    localparam logic [4:0] ST_LEN  = 5'd3;
    localparam logic [4:0] ST_SQRT = 5'd4;
    localparam logic [4:0] ST_DIVX = 5'd5;
    localparam logic [4:0] ST_DIVY = 5'd6;
    localparam logic [4:0] ST_B1   = 5'd7;
    localparam logic [4:0] ST_B2   = 5'd8;
    localparam logic [4:0] ST_B3   = 5'd9;
    localparam logic [4:0] ST_P1   = 5'd10;
    localparam logic [4:0] ST_P2   = 5'd11;
    localparam logic [4:0] ST_D1   = 5'd12;
    localparam logic [4:0] ST_D2   = 5'd13;
    localparam logic [4:0] ST_X1   = 5'd14;
    localparam logic [4:0] ST_X2   = 5'd15;
    localparam logic [4:0] ST_X3   = 5'd16;
    localparam logic [4:0] ST_Q1   = 5'd17;
    localparam logic [4:0] ST_Q2   = 5'd18;
    localparam logic [4:0] ST_Q3   = 5'd19;
    localparam logic [4:0] ST_Q4   = 5'd20;
    localparam logic [4:0] ST_E1   = 5'd21;
    localparam logic [4:0] ST_E2   = 5'd22;
    localparam logic [4:0] ST_END  = 5'd23;

    // configuration
    logic signed [31:0] ox_reg, oy_reg, dx_reg, dy_reg;
    logic [30:0]        max_reg;
    logic [31:0]        excl_reg;
    logic               excl_en_reg;

    // sequencer and datapath
    logic [4:0]                      state_reg;
    logic [31:0]                     id_reg;
    logic signed [63:0]              mx_reg, my_reg;
    logic [30:0]                     r_reg;
    logic                            last_reg;
    logic signed [63:0]              prod_reg, acc_reg;
    logic [63:0]                     rem_reg, root_reg, bit_reg;
    logic                            sqrt_sel_reg;
    logic [31:0]                     len_reg;
    logic [QW-1:0]                   quo_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic signed [UW-1:0]            ux_reg, uy_reg;
    logic signed [63:0]              b_reg, t_reg, ddx_reg, ddy_reg, ex_reg;
    logic [30:0]                     ap_reg;
    rcch_pkg::sq_dist_t              sq_reg;

    // running best
    logic                            best_found_reg;
    logic [31:0]                     best_entity_reg;
    logic [31:0]                     best_x_reg, best_y_reg;
    rcch_pkg::sq_dist_t              best_sq_reg;

    logic                            m_tvalid_reg;
    logic [rcch_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic                            m_tuser_reg;

    // shared units
    logic signed [rcch_pkg::MUL_W-1:0] mul_a, mul_b;
    logic signed [2*rcch_pkg::MUL_W-1:0] mul_p;
    logic [63:0]  sub_b;
    logic [64:0]  sub_diff;
    logic         sub_ge;
    logic [63:0]  root_nxt;

    logic [63:0]        mag_dx, mag_dy, dmx, dmy, p_abs;
    logic signed [63:0] p_val, px, py, ey;
    logic               satx, saty, spanx_ok, spany_ok;
    logic [64:0]        sq_sum;
    logic [QW-1:0]      quo_fin;
    logic signed [UW-1:0] q_signed;
    logic               s_acc, excluded;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic in_span(input logic signed [63:0] o,
                                     input logic signed [63:0] e,
                                     input logic signed [63:0] p);
        logic ok;
        if (o < e) begin
            ok = (p >= o) && (p <= e);
        end else begin
            ok = (p <= o) && (p >= e);
        end
        return ok;
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign s_acc    = s_tvalid && s_tready;
    assign excluded = excl_en_reg && (s_tdata[31:0] == excl_reg);

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MDX: begin mul_a = 35'(dx_reg); mul_b = 35'(dx_reg); end
            ST_MDY: begin mul_a = 35'(dy_reg); mul_b = 35'(dy_reg); end
            ST_B1:  begin mul_a = mx_reg[34:0]; mul_b = 35'(ux_reg); end
            ST_B2:  begin mul_a = my_reg[34:0]; mul_b = 35'(uy_reg); end
            ST_B3:  begin mul_a = mx_reg[34:0]; mul_b = 35'(uy_reg); end
            ST_P1:  begin mul_a = my_reg[34:0]; mul_b = 35'(ux_reg); end
            ST_P2:  begin mul_a = {4'd0, r_reg}; mul_b = {4'd0, r_reg}; end
            ST_D1:  begin mul_a = {4'd0, ap_reg}; mul_b = {4'd0, ap_reg}; end
            ST_X1:  begin mul_a = t_reg[34:0]; mul_b = 35'(ux_reg); end
            ST_X2:  begin mul_a = t_reg[34:0]; mul_b = 35'(uy_reg); end
            ST_Q1:  begin mul_a = {3'd0, dmx[31:0]}; mul_b = {3'd0, dmx[31:0]}; end
            ST_Q2:  begin mul_a = {3'd0, dmy[31:0]}; mul_b = {3'd0, dmy[31:0]}; end
            ST_Q3:  begin mul_a = {4'd0, max_reg}; mul_b = {4'd0, max_reg}; end
            ST_Q4:  begin mul_a = {4'd0, max_reg}; mul_b = 35'(ux_reg); end
            ST_E1:  begin mul_a = {4'd0, max_reg}; mul_b = 35'(uy_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = 70'(mul_a) * 70'(mul_b);

    // subtractor: root trial in the square root, divisor in the divide
    assign sub_b    = (state_reg == ST_SQRT) ? (root_reg + bit_reg) : {32'd0, len_reg};
    assign sub_diff = {1'b0, rem_reg} - {1'b0, sub_b};
    assign sub_ge   = !sub_diff[64];
    assign root_nxt = sub_ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);

    assign mag_dx = dx_reg[31] ? (64'd0 - 64'(dx_reg)) : 64'(dx_reg);
    assign mag_dy = dy_reg[31] ? (64'd0 - 64'(dy_reg)) : 64'(dy_reg);
    assign quo_fin = {quo_reg[QW-2:0], sub_ge};

    always_comb begin
        if (state_reg == ST_DIVX) begin
            q_signed = dx_reg[31] ? -$signed(UW'(quo_fin)) : $signed(UW'(quo_fin));
        end else begin
            q_signed = dy_reg[31] ? -$signed(UW'(quo_fin)) : $signed(UW'(quo_fin));
        end
    end

    assign p_val = (acc_reg - prod_reg) >>> FRAC_BITS;
    assign p_abs = p_val[63] ? 64'(-p_val) : 64'(p_val);

    assign dmx  = ddx_reg[63] ? 64'(-ddx_reg) : 64'(ddx_reg);
    assign dmy  = ddy_reg[63] ? 64'(-ddy_reg) : 64'(ddy_reg);
    assign satx = (dmx > 64'h0000_0000_FFFF_FFFF);
    assign saty = (dmy > 64'h0000_0000_FFFF_FFFF);
    assign sq_sum = {1'b0, acc_reg} + {1'b0, prod_reg};

    assign px = 64'(ox_reg) + ddx_reg;
    assign py = 64'(oy_reg) + ddy_reg;
    assign ey = 64'(oy_reg) + (prod_reg >>> FRAC_BITS);
    assign spanx_ok = in_span(64'(ox_reg), ex_reg, px);
    assign spany_ok = in_span(64'(oy_reg), ey, py);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ox_reg      <= '0;
            oy_reg      <= '0;
            dx_reg      <= 32'sd1 <<< FRAC_BITS;
            dy_reg      <= '0;
            max_reg     <= '0;
            excl_reg    <= '0;
            excl_en_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rcch_pkg::REG_ORIGIN_X: ox_reg      <= cfg_data;
                rcch_pkg::REG_ORIGIN_Y: oy_reg      <= cfg_data;
                rcch_pkg::REG_DIR_X:    dx_reg      <= cfg_data;
                rcch_pkg::REG_DIR_Y:    dy_reg      <= cfg_data;
                rcch_pkg::REG_MAX_DIST: max_reg     <= cfg_data[30:0];
                rcch_pkg::REG_EXCL_ID:  excl_reg    <= cfg_data;
                rcch_pkg::REG_EXCL_EN:  excl_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_p[63:0];
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    id_reg   <= s_tdata[31:0];
                    mx_reg   <= 64'(ox_reg) - 64'($signed(s_tdata[63:32]));
                    my_reg   <= 64'(oy_reg) - 64'($signed(s_tdata[95:64]));
                    r_reg    <= s_tdata[126:96];
                    last_reg <= s_tlast;
                end
            end
            ST_MDY, ST_B2, ST_P1, ST_D1, ST_Q2: acc_reg <= prod_reg;
            ST_LEN: begin
                rem_reg      <= 64'(acc_reg) + 64'(prod_reg);
                root_reg     <= '0;
                bit_reg      <= 64'd1 << 62;
                sqrt_sel_reg <= 1'b0;
            end
            ST_SQRT: begin
                if (sub_ge) begin
                    rem_reg <= sub_diff[63:0];
                end
                root_reg <= root_nxt;
                bit_reg  <= bit_reg >> 2;
                if (bit_reg[0]) begin
                    if (!sqrt_sel_reg) begin
                        // start the x divide
                        len_reg <= root_nxt[31:0];
                        rem_reg <= mag_dx;
                        quo_reg <= '0;
                        cnt_reg <= CNT_TOP;
                    end else begin
                        t_reg <= -b_reg - $signed(root_nxt);
                    end
                end
            end
            ST_DIVX, ST_DIVY: begin
                rem_reg <= (sub_ge ? sub_diff[63:0] : rem_reg) << 1;
                quo_reg <= quo_fin;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    quo_reg <= '0;
                    cnt_reg <= CNT_TOP;
                    if (state_reg == ST_DIVX) begin
                        ux_reg  <= q_signed;
                        rem_reg <= mag_dy;
                    end else begin
                        uy_reg <= q_signed;
                    end
                end
            end
            ST_B3: b_reg <= (acc_reg + prod_reg) >>> FRAC_BITS;
            ST_P2: ap_reg <= p_abs[30:0];
            ST_D2: begin
                rem_reg      <= 64'(acc_reg - prod_reg);
                root_reg     <= '0;
                bit_reg      <= 64'd1 << 62;
                sqrt_sel_reg <= 1'b1;
            end
            ST_X2: ddx_reg <= prod_reg >>> FRAC_BITS;
            ST_X3: ddy_reg <= prod_reg >>> FRAC_BITS;
            ST_Q3: begin
                // saturate either square or the sum
                if (satx || saty || sq_sum[64]) begin
                    sq_reg <= '1;
                end else begin
                    sq_reg <= sq_sum[63:0];
                end
            end
            ST_E1: ex_reg <= 64'(ox_reg) + (prod_reg >>> FRAC_BITS);
            default: ;
        endcase
    end

    // sequencer, best hit and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            best_found_reg  <= 1'b0;
            best_entity_reg <= '0;
            best_x_reg      <= '0;
            best_y_reg      <= '0;
            best_sq_reg     <= '1;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        state_reg <= excluded ? ST_END : ST_MDX;
                    end
                end
                ST_MDX: state_reg <= ST_MDY;
                ST_MDY: state_reg <= ST_LEN;
                ST_LEN: begin
                    // zero direction: nothing can be hit
                    if ((64'(acc_reg) + 64'(prod_reg)) == 64'd0) begin
                        state_reg <= ST_END;
                    end else begin
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (bit_reg[0]) begin
                        state_reg <= sqrt_sel_reg ? ST_X1 : ST_DIVX;
                    end
                end
                ST_DIVX: if (cnt_reg == '0) state_reg <= ST_DIVY;
                ST_DIVY: if (cnt_reg == '0) state_reg <= ST_B1;
                ST_B1: state_reg <= ST_B2;
                ST_B2: state_reg <= ST_B3;
                ST_B3: state_reg <= ST_P1;
                ST_P1: state_reg <= ST_P2;
                ST_P2: state_reg <= (p_abs > 64'(r_reg)) ? ST_END : ST_D1;
                ST_D1: state_reg <= ST_D2;
                ST_D2: state_reg <= ST_SQRT;
                ST_X1: state_reg <= ST_X2;
                ST_X2: state_reg <= ST_X3;
                ST_X3: state_reg <= ST_Q1;
                ST_Q1: state_reg <= ST_Q2;
                ST_Q2: state_reg <= ST_Q3;
                ST_Q3: state_reg <= ST_Q4;
                ST_Q4: state_reg <= (sq_reg > prod_reg) ? ST_END : ST_E1;
                ST_E1: state_reg <= ST_E2;
                ST_E2: begin
                    if (spanx_ok && spany_ok && (sq_reg < best_sq_reg)) begin
                        best_found_reg  <= 1'b1;
                        best_entity_reg <= id_reg;
                        best_x_reg      <= sat32(px);
                        best_y_reg      <= sat32(py);
                        best_sq_reg     <= sq_reg;
                    end
                    state_reg <= ST_END;
                end
                ST_END: begin
                    if (!last_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (!m_tvalid_reg || m_tready) begin
                        // emit the query result and clear the best hit
                        m_tvalid_reg    <= 1'b1;
                        m_tuser_reg     <= best_found_reg;
                        m_tdata_reg     <= {best_sq_reg, best_y_reg, best_x_reg,
                                            best_entity_reg};
                        best_found_reg  <= 1'b0;
                        best_entity_reg <= '0;
                        best_x_reg      <= '0;
                        best_y_reg      <= '0;
                        best_sq_reg     <= '1;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // a no-hit result carries the empty fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[159:96] == 64'hFFFF_FFFF_FFFF_FFFF)
                                 && (m_tdata[31:0] == 32'd0))
        else $error("no-hit result with non-empty fields");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !best_found_reg |-> (best_sq_reg == 64'hFFFF_FFFF_FFFF_FFFF))
        else $error("best distance set without a hit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SQRT |-> $onehot(bit_reg))
        else $error("root trial bit lost");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

endmodule
